@@ rtl/dimmer_channel_command_table_defines.svh @@
// Assertion macros for the dimmer channel command table.
`ifndef DIMMER_CHANNEL_COMMAND_TABLE_DEFINES_SVH
`define DIMMER_CHANNEL_COMMAND_TABLE_DEFINES_SVH

// same-cycle implication
`define DCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dct_pkg.sv @@
// Types, codes and helpers shared by the dimmer channel command table.
package dct_pkg;

	localparam int CH_W  = 6;
	localparam int LVL_W = 8;
	localparam int CMD_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_SET         = 4'd0;
	localparam logic [CMD_W-1:0] CMD_ON_DURATION = 4'd1;
	localparam logic [CMD_W-1:0] CMD_ON_DELAY    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_OFF         = 4'd3;
	localparam logic [CMD_W-1:0] CMD_MEMORY_OFF  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_TOGGLE      = 4'd5;
	localparam logic [CMD_W-1:0] CMD_RAMP_UP     = 4'd6;
	localparam logic [CMD_W-1:0] CMD_RAMP_DOWN   = 4'd7;

	localparam logic ACT_SINGLE = 1'b0;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESTORE_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FLOOR  = 2'd3;

	localparam logic [LVL_W-1:0] RST_LEVEL_MAX    = 8'd200;
	localparam logic [LVL_W-1:0] RST_RESTORE_CODE = 8'd251;
	localparam logic [LVL_W-1:0] RST_STEP_SIZE    = 8'd6;
	localparam logic [LVL_W-1:0] RST_LEVEL_FLOOR  = 8'd2;

	typedef struct packed {
		logic             action;
		logic [CH_W-1:0]  channel;
		logic [CMD_W-1:0] command;
		logic [LVL_W-1:0] level;
	} cmd_t;

	typedef struct packed {
		logic [CH_W-1:0]  status_channel;
		logic [LVL_W-1:0] status_level;
		logic             status_on;
		logic             last;
	} status_t;

	typedef struct packed {
		logic [LVL_W-1:0] level_max;
		logic [LVL_W-1:0] restore_code;
		logic [LVL_W-1:0] step_size;
		logic [LVL_W-1:0] level_floor;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_SET,
		OP_ON,
		OP_OFF,
		OP_TOGGLE,
		OP_RAMP_UP,
		OP_RAMP_DOWN,
		OP_STOP,
		OP_ABSENT,
		OP_GRP_MEMOFF,
		OP_GRP_RESTORE,
		OP_GRP_SET
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CH_W-1:0]  channel;
		logic [LVL_W-1:0] level;
	} item_t;

	typedef struct packed {
		logic [LVL_W-1:0] mem;
		logic             on;
		logic [LVL_W-1:0] lvl;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic pend;
	} bk_stat_t;

	function automatic logic is_group(input op_t op);
		return (op == OP_GRP_MEMOFF) || (op == OP_GRP_RESTORE)
			|| (op == OP_GRP_SET);
	endfunction

endpackage

@@ rtl/dct_ram.sv @@
// Generic single-port-write, registered-read RAM.
module dct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/dct_front.sv @@
// Front end: takes command beats and classifies them into table operations.
module dct_front #(
	parameter int CHANNELS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  dct_pkg::cmd_t                  cmd,
	output logic                           cmd_stall,
	input  logic [dct_pkg::LVL_W-1:0]      restore_code,
	output logic                           fq_valid,
	output dct_pkg::item_t                 fq_item,
	input  logic                           fq_ready
);

	logic           v_s1;
	dct_pkg::item_t item_s1;
	dct_pkg::op_t   op;
	logic           accept;

	assign cmd_stall = v_s1 && !fq_ready;
	assign accept    = cmd_valid && !cmd_stall;
	assign fq_valid  = v_s1;
	assign fq_item   = item_s1;

	always_comb begin
		op = dct_pkg::OP_STOP;
		if (cmd.action == dct_pkg::ACT_SINGLE) begin
			if (32'(cmd.channel) >= CHANNELS) begin
				op = dct_pkg::OP_ABSENT;
			end else begin
				case (cmd.command)
					dct_pkg::CMD_SET:         op = dct_pkg::OP_SET;
					dct_pkg::CMD_ON_DURATION: op = dct_pkg::OP_ON;
					dct_pkg::CMD_ON_DELAY:    op = dct_pkg::OP_ON;
					dct_pkg::CMD_OFF:         op = dct_pkg::OP_OFF;
					dct_pkg::CMD_MEMORY_OFF:  op = dct_pkg::OP_OFF;
					dct_pkg::CMD_TOGGLE:      op = dct_pkg::OP_TOGGLE;
					dct_pkg::CMD_RAMP_UP:     op = dct_pkg::OP_RAMP_UP;
					dct_pkg::CMD_RAMP_DOWN:   op = dct_pkg::OP_RAMP_DOWN;
					default:                  op = dct_pkg::OP_STOP;
				endcase
			end
		end else if (cmd.command == dct_pkg::CMD_MEMORY_OFF) begin
			op = dct_pkg::OP_GRP_MEMOFF;
		end else if (cmd.level == restore_code) begin
			op = dct_pkg::OP_GRP_RESTORE;
		end else begin
			op = dct_pkg::OP_GRP_SET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fq_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op      <= op;
			item_s1.channel <= cmd.channel;
			item_s1.level   <= cmd.level;
		end
	end

endmodule

@@ rtl/dct_queue.sv @@
// Two-entry operation queue between front and back.
module dct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dct_pkg::item_t push_item,
	output logic           ready,
	output logic           valid,
	output dct_pkg::item_t item,
	input  logic           pop
);

	dct_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign ready   = (cnt_q != 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign item    = slot_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/dct_back.sv @@
// Back end: read-modify-write of the channel store and status generation.
module dct_back #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dct_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  dct_pkg::item_t    q_item,
	output logic              q_pop,
	output logic              status_valid,
	output dct_pkg::status_t  status,
	input  logic              status_stall,
	output dct_pkg::bk_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_CH = AW'(DEPTH - 1);
	localparam int EW = $bits(dct_pkg::entry_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_FLUSH
	} state_t;

	state_t           state_q;
	dct_pkg::item_t   cur_q;
	logic [AW-1:0]    walk_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;
	logic             st_v_q;
	dct_pkg::status_t st_q;
	logic             pend_v_q;
	dct_pkg::status_t pend_q;

	logic             group;
	logic [AW-1:0]    addr;
	logic [EW-1:0]    rd_raw;
	dct_pkg::entry_t  cur;
	dct_pkg::entry_t  nxt;
	dct_pkg::status_t new_st;
	logic [dct_pkg::LVL_W-1:0] memv;
	logic [dct_pkg::LVL_W:0]   sum;
	logic [dct_pkg::LVL_W:0]   thr;
	logic             known;
	logic             out_free;
	logic             we;
	logic             st_load;
	dct_pkg::status_t st_next;

	assign group    = dct_pkg::is_group(cur_q.op);
	assign addr     = group ? walk_q : cur_q.channel[AW-1:0];
	assign cur      = rd_vld_q ? dct_pkg::entry_t'(rd_raw) : '0;
	assign out_free = !st_v_q || !status_stall;
	assign known    = (cur.lvl != '0) || cur.on || (cur.mem != '0);
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	assign status_valid = st_v_q;
	assign status       = st_q;
	assign stat.busy    = (state_q != S_IDLE);
	assign stat.pend    = pend_v_q;

	always_comb begin
		memv = (cur.mem != '0) ? cur.mem : cfg.level_max;
		sum  = {1'b0, cur.lvl} + {1'b0, cfg.step_size};
		thr  = {1'b0, cfg.step_size} + {1'b0, cfg.level_floor};
		nxt  = cur;
		case (cur_q.op)
			dct_pkg::OP_SET: begin
				nxt.lvl = (cur_q.level > cfg.level_max) ? cfg.level_max
					: cur_q.level;
				nxt.on  = (nxt.lvl != '0);
			end
			dct_pkg::OP_ON: begin
				nxt.on  = 1'b1;
				nxt.lvl = memv;
			end
			dct_pkg::OP_OFF: begin
				nxt.on  = 1'b0;
				nxt.lvl = '0;
			end
			dct_pkg::OP_TOGGLE: begin
				nxt.on  = !cur.on;
				nxt.lvl = cur.on ? '0 : memv;
			end
			dct_pkg::OP_RAMP_UP: begin
				nxt.on  = 1'b1;
				nxt.lvl = (sum > {1'b0, cfg.level_max}) ? cfg.level_max
					: sum[dct_pkg::LVL_W-1:0];
			end
			dct_pkg::OP_RAMP_DOWN: begin
				nxt.lvl = ({1'b0, cur.lvl} < thr) ? cfg.level_floor
					: cur.lvl - cfg.step_size;
			end
			dct_pkg::OP_GRP_MEMOFF: begin
				if (cur.on) begin
					nxt.mem = cur.lvl;
				end
				nxt.lvl = '0;
				nxt.on  = 1'b0;
			end
			dct_pkg::OP_GRP_RESTORE: begin
				if (cur.mem != '0) begin
					nxt.lvl = cur.mem;
					nxt.on  = 1'b1;
				end
			end
			dct_pkg::OP_GRP_SET: begin
				nxt.lvl = cur_q.level;
				nxt.on  = (cur_q.level != '0);
			end
			default: begin
				nxt = cur;
			end
		endcase
		if (!group && nxt.on && (nxt.lvl != '0)) begin
			nxt.mem = nxt.lvl;
		end

		new_st.status_channel = group ? dct_pkg::CH_W'(walk_q) : cur_q.channel;
		new_st.status_level   = nxt.lvl;
		new_st.status_on      = nxt.on;
		new_st.last           = !group;
		if (cur_q.op == dct_pkg::OP_ABSENT) begin
			new_st.status_level = '0;
			new_st.status_on    = 1'b0;
		end
	end

	always_comb begin
		we = 1'b0;
		if (state_q == S_EXEC) begin
			if (group) begin
				we = known && (!pend_v_q || out_free);
			end else begin
				we = out_free && (cur_q.op != dct_pkg::OP_ABSENT);
			end
		end
	end

	// status beat loaded into the output register this cycle
	always_comb begin
		st_load = 1'b0;
		st_next = new_st;
		case (state_q)
			S_EXEC: begin
				if (group) begin
					if (known && pend_v_q && out_free) begin
						st_load = 1'b1;
						st_next = pend_q;
					end
				end else if (out_free) begin
					st_load = 1'b1;
				end
			end
			S_FLUSH: begin
				if (pend_v_q && out_free) begin
					st_load      = 1'b1;
					st_next      = pend_q;
					st_next.last = 1'b1;
				end
			end
			default: begin
				st_load = 1'b0;
			end
		endcase
	end

	dct_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (nxt),
		.raddr (addr),
		.rdata (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			walk_q   <= '0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			st_v_q   <= 1'b0;
			st_q     <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
		end else begin
			rd_vld_q <= vld_q[addr];
			if (we) begin
				vld_q[addr] <= 1'b1;
			end
			if (st_load) begin
				st_v_q <= 1'b1;
				st_q   <= st_next;
			end else if (!status_stall) begin
				st_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q   <= q_item;
						walk_q  <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (group) begin
						if (!known || !pend_v_q || out_free) begin
							if (known) begin
								pend_q   <= new_st;
								pend_v_q <= 1'b1;
							end
							if (walk_q == LAST_CH) begin
								state_q <= S_FLUSH;
							end else begin
								walk_q  <= walk_q + AW'(1);
								state_q <= S_READ;
							end
						end
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/dimmer_channel_command_table.sv @@
// Top level of the dimmer channel command table.
// A single-channel command returns its one status after its beat passes the
// front register, the queue, a store read and an execute step. A group command
// walks min(CHANNELS, 64) channels, each with a read and then an execute and
// write back, since the store has a single registered read port, and ends with
// a final flush; only channels that hold state give a status, so a group over
// an empty table gives none. Reset clears the store at once through per-entry
// valid flags, so no clearing pass follows reset. A stalled status output holds
// the back end only when it has a status to deliver; the two-entry queue keeps
// taking command beats meanwhile until it is full.
`include "dimmer_channel_command_table_defines.svh"

module dimmer_channel_command_table #(
	parameter int CHANNELS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dct_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dct_pkg::LVL_W-1:0]         cfg_data,
	input  logic                              cmd_valid,
	input  dct_pkg::cmd_t                     cmd,
	output logic                              cmd_stall,
	output logic                              status_valid,
	output dct_pkg::status_t                  status,
	input  logic                              status_stall
);

	localparam int DEPTH = (CHANNELS < 64) ? CHANNELS : 64;

	dct_pkg::cfg_t     cfg_q;
	logic              fq_valid;
	dct_pkg::item_t    fq_item;
	logic              fq_ready;
	logic              q_valid;
	dct_pkg::item_t    q_item;
	logic              q_pop;
	dct_pkg::bk_stat_t bk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_max    <= dct_pkg::RST_LEVEL_MAX;
			cfg_q.restore_code <= dct_pkg::RST_RESTORE_CODE;
			cfg_q.step_size    <= dct_pkg::RST_STEP_SIZE;
			cfg_q.level_floor  <= dct_pkg::RST_LEVEL_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				dct_pkg::REG_LEVEL_MAX:    cfg_q.level_max    <= cfg_data;
				dct_pkg::REG_RESTORE_CODE: cfg_q.restore_code <= cfg_data;
				dct_pkg::REG_STEP_SIZE:    cfg_q.step_size    <= cfg_data;
				dct_pkg::REG_LEVEL_FLOOR:  cfg_q.level_floor  <= cfg_data;
				default:                   cfg_q              <= cfg_q;
			endcase
		end
	end

	dct_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_stall    (cmd_stall),
		.restore_code (cfg_q.restore_code),
		.fq_valid     (fq_valid),
		.fq_item      (fq_item),
		.fq_ready     (fq_ready)
	);

	dct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_valid),
		.push_item (fq_item),
		.ready     (fq_ready),
		.valid     (q_valid),
		.item      (q_item),
		.pop       (q_pop)
	);

	dct_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.status_valid (status_valid),
		.status       (status),
		.status_stall (status_stall),
		.stat         (bk)
	);

	// input held back only while the front register is waiting on a full queue
	`DCT_ASSERT_NOW(a_stall_needs_front, cmd_stall, fq_valid && !fq_ready, "stall, queue not full")
	// a non-final group status always leaves a pending one behind it
	`DCT_ASSERT_NOW(a_nonlast_has_pend, status_valid && !status.last, bk.pend, "run lost final")
	// back end takes from the queue only when idle, and is busy afterwards
	`DCT_ASSERT_NEXT(a_pop_starts_work, q_pop, bk.busy, "pop did not start work")

endmodule

@@ tb/tb_dimmer_channel_command_table.sv @@
// Testbench for the dimmer channel command table: directed and random beats vs. predictor.
module tb_dimmer_channel_command_table;
	timeunit 1ns;
	timeprecision 1ps;

	import dct_pkg::*;

	localparam int NUM_CH = 64;
	localparam logic ACT_GROUP = 1'b1;
	localparam logic [CMD_W-1:0] CMD_STOP = 4'd8;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LVL_W-1:0] cfg_data = '0;
	logic cmd_valid = 1'b0;
	cmd_t cmd_beat = '0;
	logic cmd_stall;
	logic status_valid;
	status_t status_beat;
	logic status_stall = 1'b0;

	// table shadow and register shadow
	logic [LVL_W-1:0] chan_level [NUM_CH];
	bit chan_on [NUM_CH];
	logic [LVL_W-1:0] chan_mem [NUM_CH];
	logic [LVL_W-1:0] level_max_r = RST_LEVEL_MAX;
	logic [LVL_W-1:0] restore_code_r = RST_RESTORE_CODE;
	logic [LVL_W-1:0] step_r = RST_STEP_SIZE;
	logic [LVL_W-1:0] floor_r = RST_LEVEL_FLOOR;

	cmd_t pending_cmds [$];
	status_t expected_status [$];
	int mismatches = 0;
	bit beat_done = 0;
	bit quiet = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;

	dimmer_channel_command_table #(.CHANNELS(NUM_CH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd(cmd_beat),
		.cmd_stall(cmd_stall),
		.status_valid(status_valid),
		.status(status_beat),
		.status_stall(status_stall)
	);

	always #5 clk = ~clk;

	function automatic void apply_command(input cmd_t c);
		int lvl;
		int mem;
		int req;
		int i;
		bit on;
		bit have;
		status_t held;
		req = c.level;
		if (c.action == ACT_SINGLE) begin
			lvl = chan_level[c.channel];
			on = chan_on[c.channel];
			mem = (chan_mem[c.channel] != 0) ? chan_mem[c.channel] : level_max_r;
			case (c.command)
				CMD_TOGGLE: begin
					on = !on;
					lvl = on ? mem : 0;
				end
				CMD_ON_DURATION, CMD_ON_DELAY: begin
					on = 1;
					lvl = mem;
				end
				CMD_OFF, CMD_MEMORY_OFF: begin
					on = 0;
					lvl = 0;
				end
				CMD_SET: begin
					lvl = (req > level_max_r) ? level_max_r : req;
					on = (lvl > 0);
				end
				CMD_RAMP_UP: begin
					on = 1;
					lvl = (lvl + step_r > level_max_r) ? level_max_r : lvl + step_r;
				end
				CMD_RAMP_DOWN: begin
					lvl = (lvl < step_r + floor_r) ? floor_r : lvl - step_r;
				end
				default: begin
				end
			endcase
			if (on && lvl > 0)
				chan_mem[c.channel] = 8'(lvl);
			chan_level[c.channel] = 8'(lvl);
			chan_on[c.channel] = on;
			held.status_channel = c.channel;
			held.status_level = 8'(lvl);
			held.status_on = on;
			held.last = 1'b1;
			expected_status.push_back(held);
		end else begin
			have = 0;
			held = '0;
			for (i = 0; i < NUM_CH; i++) begin
				if (chan_level[i] == 0 && !chan_on[i] && chan_mem[i] == 0)
					continue;
				if (c.command == CMD_MEMORY_OFF) begin
					if (chan_on[i])
						chan_mem[i] = chan_level[i];
					chan_level[i] = '0;
					chan_on[i] = 0;
				end else if (c.level == restore_code_r) begin
					if (chan_mem[i] != 0) begin
						chan_level[i] = chan_mem[i];
						chan_on[i] = 1;
					end
				end else begin
					chan_level[i] = c.level;
					chan_on[i] = (req > 0);
				end
				if (have)
					expected_status.push_back(held);
				held.status_channel = 6'(i);
				held.status_level = chan_level[i];
				held.status_on = chan_on[i];
				held.last = 1'b0;
				have = 1;
			end
			if (have) begin
				held.last = 1'b1;
				expected_status.push_back(held);
			end
		end
	endfunction

	function automatic cmd_t mk_cmd(input logic act, input int ch, input logic [CMD_W-1:0] op,
			input int lvl);
		cmd_t c;
		c.action = act;
		c.channel = 6'(ch);
		c.command = op;
		c.level = 8'(lvl);
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.action = ($urandom_range(0, 99) < 15) ? ACT_GROUP : ACT_SINGLE;
		c.channel = ($urandom_range(0, 99) < 60) ? 6'($urandom_range(0, 7))
			: 6'($urandom_range(0, 63));
		if ($urandom_range(0, 99) < 88)
			c.command = 4'($urandom_range(0, 8));
		else
			c.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		case ($urandom_range(0, 5))
			0: c.level = '0;
			1: c.level = '1;
			2: c.level = level_max_r;
			3: c.level = restore_code_r;
			default: c.level = 8'($urandom_range(0, 255));
		endcase
		if (c.action == ACT_GROUP) begin
			if ($urandom_range(0, 99) < 30)
				c.command = CMD_MEMORY_OFF;
			else if ($urandom_range(0, 99) < 40)
				c.level = restore_code_r;
		end
		return c;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_LEVEL_MAX: level_max_r = val;
			REG_RESTORE_CODE: restore_code_r = val;
			REG_STEP_SIZE: step_r = val;
			REG_LEVEL_FLOOR: floor_r = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input int lmax, input int rcode, input int step, input int floor_v);
		write_reg(REG_LEVEL_MAX, 8'(lmax));
		write_reg(REG_RESTORE_CODE, 8'(rcode));
		write_reg(REG_STEP_SIZE, 8'(step));
		write_reg(REG_LEVEL_FLOOR, 8'(floor_v));
	endtask

	task automatic push_random(input int n);
		repeat (n) pending_cmds.push_back(rand_cmd());
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || cmd_valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// command side: take beat, then drive next at falling edge
	always @(posedge clk) begin : take_beat
		if (arst_n && cmd_valid && !cmd_stall) begin
			apply_command(cmd_beat);
			beat_done = 1;
		end
	end

	always @(negedge clk) begin : drive_cmd
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || beat_done) begin
			beat_done = 0;
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				if (!quiet && hold_left == 0 && $urandom_range(0, 99) < 20) begin
					gap_left = $urandom_range(1, 17) - 1;
					cmd_valid <= 1'b0;
				end else begin
					cmd_beat <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// status side backpressure
	always @(negedge clk) begin : drive_stall
		if (!arst_n) begin
			status_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			status_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			status_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 15) begin
			stall_left = $urandom_range(1, 17) - 1;
			status_stall <= 1'b1;
		end else begin
			status_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_status
		status_t want;
		if (arst_n && status_valid && !status_stall) begin
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected status beat: ch %0d lvl %0d on %0b last %0b",
						status_beat.status_channel, status_beat.status_level,
						status_beat.status_on, status_beat.last);
			end else begin
				want = expected_status.pop_front();
				if (status_beat.status_channel !== want.status_channel
						|| status_beat.status_level !== want.status_level
						|| status_beat.status_on !== want.status_on
						|| status_beat.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: got %0d/%0d/%0b/%0b want %0d/%0d/%0b/%0b",
							status_beat.status_channel, status_beat.status_level,
							status_beat.status_on, status_beat.last,
							want.status_channel, want.status_level,
							want.status_on, want.last);
				end
			end
		end
	end

	initial begin
		#(20_000_000);
		$display("FAILURE");
		$finish;
	end

	initial begin
		for (int i = 0; i < NUM_CH; i++) begin
			chan_level[i] = '0;
			chan_on[i] = 0;
			chan_mem[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed, reset register values
		pending_cmds.push_back(mk_cmd(ACT_GROUP, 0, CMD_SET, 50));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 0, CMD_SET, 255));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 63, CMD_SET, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 1, CMD_SET, 100));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 2, CMD_ON_DURATION, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 1, CMD_ON_DELAY, 7));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 1, CMD_TOGGLE, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 1, CMD_TOGGLE, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 5, CMD_TOGGLE, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 0, CMD_RAMP_UP, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 3, CMD_RAMP_UP, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 3, CMD_RAMP_DOWN, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 1, CMD_RAMP_DOWN, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 2, CMD_OFF, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 0, CMD_MEMORY_OFF, 0));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 1, CMD_STOP, 255));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 1, CMD_UNUSED_HI, 255));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 4, CMD_UNUSED_LO, 0));
		pending_cmds.push_back(mk_cmd(ACT_GROUP, 63, CMD_MEMORY_OFF, 0));
		pending_cmds.push_back(mk_cmd(ACT_GROUP, 0, CMD_SET, RST_RESTORE_CODE));
		pending_cmds.push_back(mk_cmd(ACT_GROUP, 0, CMD_SET, 255));
		pending_cmds.push_back(mk_cmd(ACT_GROUP, 0, CMD_SET, 0));
		pending_cmds.push_back(mk_cmd(ACT_GROUP, 0, CMD_TOGGLE, RST_RESTORE_CODE));
		pending_cmds.push_back(mk_cmd(ACT_SINGLE, 63, CMD_SET, 255));
		wait_idle();

		write_all(255, 0, 255, 0);
		push_random(20);
		wait_idle();

		write_all(1, 255, 1, 255);
		push_random(18);
		wait_idle();

		// zero full level
		write_all(0, $urandom_range(0, 255), $urandom_range(1, 255), $urandom_range(0, 255));
		push_random(10);
		wait_idle();

		// long receiver hold while commands keep coming
		write_all($urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(1, 255),
			$urandom_range(0, 255));
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		push_random(24);
		wait_idle();

		write_all(RST_LEVEL_MAX, RST_RESTORE_CODE, RST_STEP_SIZE, RST_LEVEL_FLOOR);
		quiet = 1;
		push_random(14);
		wait_idle();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
